FILE: design/flash_block_page_map_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the flash block page map
// Shorthand for clocked properties used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FLASH_BLOCK_PAGE_MAP_TOP_MACROS_SVH
`define FLASH_BLOCK_PAGE_MAP_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BLKMAP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BLKMAP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/blkmap_pkg.sv
// ----------------------------------------------------------------------------
// Block page map package
// Types, codes and defaults shared by the page map controller and its cells.
// ----------------------------------------------------------------------------
package blkmap_pkg;

   // Default values of the top level parameters.
   localparam int DEF_TABLE_ENTRIES   = 16;
   localparam int DEF_MAX_BLOCK_BYTES = 256;
   localparam int DEF_SEQ_INVALID     = 0;
   localparam int DEF_SEQ_FIRST       = 1;

   // Special block type codes and sequence values.
   localparam logic [7:0]  TYPE_NONE    = 8'h00;
   localparam logic [7:0]  TYPE_ERASED  = 8'hFF;
   localparam logic [15:0] SEQ_ALL_ONES = 16'hFFFF;

   // Register file of the configuration port.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_START = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_LAST  = 1'b1;

   typedef enum logic [1:0] {
      MODE_SCAN   = 2'd0,
      MODE_ALLOC  = 2'd1,
      MODE_LOOKUP = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_LEN   = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_NO_PAGE   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_DECODE,
      CTRL_SLOT_WAIT,
      CTRL_PAGE_SEARCH
   } ctrl_state_type;

   // A slot probe looks for a type or the first empty slot; a page probe
   // checks whether any occupied slot holds a candidate page.
   typedef enum logic {
      PROBE_SLOT,
      PROBE_PAGE
   } probe_kind_type;

   // Probe word that walks down the chain of cells, one cell per cycle.
   typedef struct packed {
      logic           valid;
      probe_kind_type kind;
      logic [15:0]    key;
      logic           inrange;
      logic           hit;
      logic           exact;
      logic [15:0]    page;
      logic [15:0]    seq;
   } probe_type;

   // Table update command broadcast to all cells.
   typedef struct packed {
      logic        clear;
      logic        wr_en;
      logic [7:0]  ent_type;
      logic [15:0] page;
      logic [15:0] seq;
   } tbl_cmd_type;

endpackage

FILE: design/blkmap_cell.sv
// ----------------------------------------------------------------------------
// Block page map cell
// Holds one table slot and one stage of the probe chain.
// ----------------------------------------------------------------------------
module blkmap_cell #(
   parameter int TABLE_ENTRIES = blkmap_pkg::DEF_TABLE_ENTRIES,
   parameter int CELL_IDX      = 0,
   parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  blkmap_pkg::probe_type   up_probe,
   input  logic [IDX_W-1:0]        up_idx,
   output blkmap_pkg::probe_type   dn_probe,
   output logic [IDX_W-1:0]        dn_idx,
   input  blkmap_pkg::tbl_cmd_type cmd,
   input  logic [IDX_W-1:0]        cmd_idx
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic [7:0]            ent_type_ff;
   logic [15:0]           ent_page_ff;
   logic [15:0]           ent_seq_ff;
   blkmap_pkg::probe_type probe_ff;
   blkmap_pkg::probe_type probe_in;
   logic [IDX_W-1:0]      idx_ff;
   logic [IDX_W-1:0]      idx_in;

   // Compare the passing probe against this slot.
   always_comb begin
      probe_in = up_probe;
      idx_in   = up_idx;
      if (up_probe.valid) begin
         case (up_probe.kind)
            blkmap_pkg::PROBE_SLOT: begin
               // The first slot that holds the type or is empty claims the probe.
               if (!up_probe.hit && (ent_type_ff == up_probe.key[7:0] ||
                                     ent_type_ff == blkmap_pkg::TYPE_NONE)) begin
                  probe_in.hit   = 1'b1;
                  probe_in.exact = (ent_type_ff == up_probe.key[7:0]);
                  probe_in.page  = ent_page_ff;
                  probe_in.seq   = ent_seq_ff;
                  idx_in         = MY_IDX;
               end
            end
            blkmap_pkg::PROBE_PAGE: begin
               if (ent_type_ff != blkmap_pkg::TYPE_NONE && ent_page_ff == up_probe.key) begin
                  probe_in.hit = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Probe stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
         idx_ff   <= '0;
      end else begin
         probe_ff <= probe_in;
         idx_ff   <= idx_in;
      end
   end

   // Slot contents: cleared by reset or a clear command, loaded when addressed.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         ent_type_ff <= blkmap_pkg::TYPE_NONE;
         ent_page_ff <= '0;
         ent_seq_ff  <= '0;
      end else if (cmd.wr_en && cmd_idx == MY_IDX) begin
         ent_type_ff <= cmd.ent_type;
         ent_page_ff <= cmd.page;
         ent_seq_ff  <= cmd.seq;
      end
   end

   assign dn_probe = probe_ff;
   assign dn_idx   = idx_ff;

endmodule

FILE: design/blkmap_ctrl.sv
// ----------------------------------------------------------------------------
// Block page map controller
// Decodes a command word, launches probes into the cell chain, evaluates
// what comes out of it, updates the table and produces the result word.
// ----------------------------------------------------------------------------
module blkmap_ctrl #(
   parameter int TABLE_ENTRIES   = blkmap_pkg::DEF_TABLE_ENTRIES,
   parameter int MAX_BLOCK_BYTES = blkmap_pkg::DEF_MAX_BLOCK_BYTES,
   parameter int SEQ_INVALID     = blkmap_pkg::DEF_SEQ_INVALID,
   parameter int SEQ_FIRST       = blkmap_pkg::DEF_SEQ_FIRST,
   parameter int IDX_W           = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_mode,
   input  logic [7:0]              req_block_type,
   input  logic [15:0]             req_block_len,
   input  logic [15:0]             req_hdr_seq,
   input  logic [15:0]             req_hdr_page,
   input  logic [15:0]             area_start,
   input  logic [15:0]             area_last,
   output blkmap_pkg::probe_type   launch,
   input  blkmap_pkg::probe_type   exit_probe,
   input  logic [IDX_W-1:0]        exit_idx,
   output blkmap_pkg::tbl_cmd_type cmd,
   output logic [IDX_W-1:0]        cmd_idx,
   output logic                    rsp_strobe,
   output logic [2:0]              rsp_status,
   output logic [15:0]             rsp_page_num,
   output logic [15:0]             rsp_seq_out
);

   localparam logic [15:0] SEQ_INV_V   = 16'(SEQ_INVALID);
   localparam logic [15:0] SEQ_FIRST_V = 16'(SEQ_FIRST);
   localparam logic [15:0] MAX_LEN_V   = 16'(MAX_BLOCK_BYTES);

   // Next sequence number with wrap; the all-ones and invalid values are skipped.
   function automatic logic [15:0] next_seq(input logic [15:0] s);
      logic [15:0] n;
      n = s + 16'd1;
      if (n == blkmap_pkg::SEQ_ALL_ONES || n == SEQ_INV_V) begin
         n = SEQ_FIRST_V;
      end
      return n;
   endfunction

   blkmap_pkg::ctrl_state_type state_ff, state_in;
   blkmap_pkg::mode_type       mode_ff;
   logic [7:0]                 btype_ff;
   logic [15:0]                blen_ff;
   logic [15:0]                hseq_ff;
   logic [15:0]                hpage_ff;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [15:0]                oldseq_ff, oldseq_in;
   logic [16:0]                cand_ff, cand_in;
   logic                       rsp_strobe_ff, rsp_strobe_in;
   blkmap_pkg::status_type     rsp_status_ff, rsp_status_in;
   logic [15:0]                rsp_page_ff, rsp_page_in;
   logic [15:0]                rsp_seq_ff, rsp_seq_in;

   logic        accept;
   logic        bad_len;
   logic        decode_launch;
   logic        slot_exit;
   logic        page_exit;
   logic [15:0] old_page;
   logic [15:0] old_seq;
   logic        scan_take;

   assign busy   = (state_ff != blkmap_pkg::CTRL_IDLE);
   assign accept = start && !busy;

   // Command checks on the captured word.
   assign bad_len = (blen_ff == 16'd0) || (blen_ff > MAX_LEN_V);
   assign decode_launch =
      (mode_ff == blkmap_pkg::MODE_SCAN) ?
         (btype_ff != blkmap_pkg::TYPE_NONE && btype_ff != blkmap_pkg::TYPE_ERASED) :
         (mode_ff != blkmap_pkg::MODE_CLEAR && !bad_len &&
          btype_ff != blkmap_pkg::TYPE_NONE);

   // Probe words leaving the chain, and the slot they found.
   assign slot_exit = exit_probe.valid && exit_probe.kind == blkmap_pkg::PROBE_SLOT;
   assign page_exit = exit_probe.valid && exit_probe.kind == blkmap_pkg::PROBE_PAGE;
   assign old_page  = exit_probe.exact ? exit_probe.page : 16'd0;
   assign old_seq   = exit_probe.exact ? exit_probe.seq : SEQ_INV_V;
   assign scan_take = (hseq_ff > old_seq);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         blkmap_pkg::CTRL_IDLE: begin
            if (accept) begin
               state_in = blkmap_pkg::CTRL_DECODE;
            end
         end
         blkmap_pkg::CTRL_DECODE: begin
            state_in = decode_launch ? blkmap_pkg::CTRL_SLOT_WAIT : blkmap_pkg::CTRL_IDLE;
         end
         blkmap_pkg::CTRL_SLOT_WAIT: begin
            if (slot_exit) begin
               if (mode_ff == blkmap_pkg::MODE_ALLOC && exit_probe.hit) begin
                  state_in = blkmap_pkg::CTRL_PAGE_SEARCH;
               end else begin
                  state_in = blkmap_pkg::CTRL_IDLE;
               end
            end
         end
         blkmap_pkg::CTRL_PAGE_SEARCH: begin
            if (page_exit && (!exit_probe.inrange || !exit_probe.hit)) begin
               state_in = blkmap_pkg::CTRL_IDLE;
            end
         end
         default: begin
            state_in = blkmap_pkg::CTRL_IDLE;
         end
      endcase
   end

   // Outputs: probes, table commands and the result word.
   always_comb begin
      launch        = '0;
      cmd           = '0;
      cmd_idx       = '0;
      idx_in        = idx_ff;
      oldseq_in     = oldseq_ff;
      cand_in       = cand_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = blkmap_pkg::ST_OK;
      rsp_page_in   = '0;
      rsp_seq_in    = '0;
      unique case (state_ff)
         blkmap_pkg::CTRL_IDLE: begin
         end
         blkmap_pkg::CTRL_DECODE: begin
            if (decode_launch) begin
               launch.valid = 1'b1;
               launch.kind  = blkmap_pkg::PROBE_SLOT;
               launch.key   = {8'h00, btype_ff};
            end else begin
               rsp_strobe_in = 1'b1;
               if (mode_ff == blkmap_pkg::MODE_CLEAR) begin
                  cmd.clear = 1'b1;
               end else if (mode_ff != blkmap_pkg::MODE_SCAN) begin
                  rsp_status_in = bad_len ? blkmap_pkg::ST_BAD_LEN : blkmap_pkg::ST_NOT_FOUND;
               end
            end
         end
         blkmap_pkg::CTRL_SLOT_WAIT: begin
            if (slot_exit) begin
               case (mode_ff)
                  blkmap_pkg::MODE_SCAN: begin
                     rsp_strobe_in = 1'b1;
                     if (!exit_probe.hit) begin
                        rsp_status_in = blkmap_pkg::ST_FULL;
                     end else begin
                        // Create or refresh the slot; a newer header wins.
                        cmd.wr_en    = 1'b1;
                        cmd.ent_type = btype_ff;
                        cmd.page     = scan_take ? hpage_ff : old_page;
                        cmd.seq      = scan_take ? hseq_ff : old_seq;
                        cmd_idx      = exit_idx;
                        rsp_page_in  = cmd.page;
                        rsp_seq_in   = cmd.seq;
                     end
                  end
                  blkmap_pkg::MODE_ALLOC: begin
                     if (!exit_probe.hit) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = blkmap_pkg::ST_FULL;
                     end else begin
                        idx_in    = exit_idx;
                        oldseq_in = old_seq;
                        cand_in   = {1'b0, area_start} + 17'd1;
                        // A new type takes its slot now, even if no page is free.
                        if (!exit_probe.exact) begin
                           cmd.wr_en    = 1'b1;
                           cmd.ent_type = btype_ff;
                           cmd.page     = '0;
                           cmd.seq      = SEQ_INV_V;
                           cmd_idx      = exit_idx;
                        end
                     end
                  end
                  default: begin
                     // Lookup.
                     rsp_strobe_in = 1'b1;
                     if (exit_probe.hit && exit_probe.exact) begin
                        rsp_page_in = exit_probe.page;
                        rsp_seq_in  = exit_probe.seq;
                     end else begin
                        rsp_status_in = blkmap_pkg::ST_NOT_FOUND;
                     end
                  end
               endcase
            end
         end
         blkmap_pkg::CTRL_PAGE_SEARCH: begin
            // Feed ascending candidate pages, one per cycle.
            launch.valid   = 1'b1;
            launch.kind    = blkmap_pkg::PROBE_PAGE;
            launch.key     = cand_ff[15:0];
            launch.inrange = (cand_ff <= {1'b0, area_last});
            cand_in        = cand_ff + 17'd1;
            // The first candidate that leaves the chain unclaimed or out of range decides.
            if (page_exit && (!exit_probe.inrange || !exit_probe.hit)) begin
               rsp_strobe_in = 1'b1;
               if (!exit_probe.inrange) begin
                  rsp_status_in = blkmap_pkg::ST_NO_PAGE;
               end else begin
                  cmd.wr_en    = 1'b1;
                  cmd.ent_type = btype_ff;
                  cmd.page     = exit_probe.key;
                  cmd.seq      = next_seq(oldseq_ff);
                  cmd_idx      = idx_ff;
                  rsp_page_in  = cmd.page;
                  rsp_seq_in   = cmd.seq;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= blkmap_pkg::CTRL_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Command word capture and working registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= blkmap_pkg::mode_type'(req_mode);
         btype_ff <= req_block_type;
         blen_ff  <= req_block_len;
         hseq_ff  <= req_hdr_seq;
         hpage_ff <= req_hdr_page;
      end
      idx_ff        <= idx_in;
      oldseq_ff     <= oldseq_in;
      cand_ff       <= cand_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_seq_ff    <= rsp_seq_in;
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_page_num = rsp_page_ff;
   assign rsp_seq_out  = rsp_seq_ff;

endmodule

FILE: design/flash_block_page_map_top.sv
// ----------------------------------------------------------------------------
// Flash block page map
// Clear, ignored scans and rejected commands are answered from the decode
// state; scan and lookup after the slot walk through the cell chain; allocate
// after the slot walk and the candidate page stream. One command word is in
// work at a time. Reset empties the table and sets the area to 0..65535.
// ----------------------------------------------------------------------------
module flash_block_page_map_top #(
   parameter int TABLE_ENTRIES   = blkmap_pkg::DEF_TABLE_ENTRIES,
   parameter int MAX_BLOCK_BYTES = blkmap_pkg::DEF_MAX_BLOCK_BYTES,
   parameter int SEQ_INVALID     = blkmap_pkg::DEF_SEQ_INVALID,
   parameter int SEQ_FIRST       = blkmap_pkg::DEF_SEQ_FIRST
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_mode,
   input  logic [7:0]                       req_block_type,
   input  logic [15:0]                      req_block_len,
   input  logic [15:0]                      req_hdr_seq,
   input  logic [15:0]                      req_hdr_page,
   output logic                             rsp_strobe,
   output logic [2:0]                       rsp_status,
   output logic [15:0]                      rsp_page_num,
   output logic [15:0]                      rsp_seq_out,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [blkmap_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                      csr_wdata
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   logic [15:0]             area_start_ff;
   logic [15:0]             area_last_ff;
   blkmap_pkg::probe_type   probe_chain [0:TABLE_ENTRIES];
   logic [IDX_W-1:0]        idx_chain   [0:TABLE_ENTRIES];
   blkmap_pkg::tbl_cmd_type cmd;
   logic [IDX_W-1:0]        cmd_idx;

   // Configuration registers; a write is taken in any cycle.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         area_start_ff <= 16'h0000;
         area_last_ff  <= 16'hFFFF;
      end else if (csr_valid) begin
         unique case (csr_index)
            blkmap_pkg::CSR_AREA_START: area_start_ff <= csr_wdata;
            blkmap_pkg::CSR_AREA_LAST:  area_last_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Sequencer.
   blkmap_ctrl #(
      .TABLE_ENTRIES  (TABLE_ENTRIES),
      .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES),
      .SEQ_INVALID    (SEQ_INVALID),
      .SEQ_FIRST      (SEQ_FIRST),
      .IDX_W          (IDX_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_block_type(req_block_type),
      .req_block_len (req_block_len),
      .req_hdr_seq   (req_hdr_seq),
      .req_hdr_page  (req_hdr_page),
      .area_start    (area_start_ff),
      .area_last     (area_last_ff),
      .launch        (probe_chain[0]),
      .exit_probe    (probe_chain[TABLE_ENTRIES]),
      .exit_idx      (idx_chain[TABLE_ENTRIES]),
      .cmd           (cmd),
      .cmd_idx       (cmd_idx),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_page_num  (rsp_page_num),
      .rsp_seq_out   (rsp_seq_out)
   );

   assign idx_chain[0] = '0;

   // Chain of table cells; probes move one cell per cycle.
   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      blkmap_cell #(
         .TABLE_ENTRIES(TABLE_ENTRIES),
         .CELL_IDX     (g),
         .IDX_W        (IDX_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .up_probe(probe_chain[g]),
         .up_idx  (idx_chain[g]),
         .dn_probe(probe_chain[g+1]),
         .dn_idx  (idx_chain[g+1]),
         .cmd     (cmd),
         .cmd_idx (cmd_idx)
      );
   end

endmodule

FILE: design/blkmap_checker.sv
// ----------------------------------------------------------------------------
// Block page map port checker
// Watches the top level ports for command and result ordering slips.
// ----------------------------------------------------------------------------
`include "flash_block_page_map_top_macros.svh"

module blkmap_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_page_num,
   input logic [15:0] rsp_seq_out
);

   // An accepted command word keeps the block busy in the next cycle.
   `BLKMAP_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "not busy after accept")

   // A result ends the work on a command word.
   `BLKMAP_ASSERT_SAME(a_result_ends_busy, rsp_strobe, $fell(busy), "result without busy drop")

   // Results never come in two adjacent cycles.
   `BLKMAP_ASSERT_NEXT(a_single_result, rsp_strobe, !rsp_strobe, "back to back results")

   // Failed commands return zero page and sequence.
   `BLKMAP_ASSERT_SAME(a_error_zero, rsp_strobe && rsp_status != blkmap_pkg::ST_OK,
      rsp_page_num == 16'd0 && rsp_seq_out == 16'd0, "error result carries data")

endmodule

bind flash_block_page_map_top blkmap_checker u_blkmap_checker (.*);
